// ===== rtl/urm_pkg.sv =====
// ----------------------------------------------------------------------------
// urm_pkg
// Shared types, constants and helpers for the ultrasonic range median filter.
// ----------------------------------------------------------------------------
package urm_pkg;

    // Field widths
    localparam int WIDTH_W = 16;     // echo pulse width, us
    localparam int SPEED_W = 9;      // speed of sound, m/s
    localparam int DIST_W  = 14;     // distance, mm
    localparam int WSIZE_W = 4;      // window size register

    // Median window depth and derived index widths
    localparam int MAX_WINDOW = 9;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int WIN_W      = $clog2(MAX_WINDOW + 1);

    // width * speed, then floor(x / 2000) as (x * RECIP_MULT) >> RECIP_SHIFT.
    // RECIP_MULT = ceil(2^36 / 2000); the rounding error times the largest
    // product stays below 2^36, so the quotient is exact without correction.
    localparam int PROD_W       = WIDTH_W + SPEED_W;
    localparam int RECIP_W      = 26;
    localparam int RECIP_SHIFT  = 36;
    localparam int RECIP_PROD_W = PROD_W + RECIP_W;
    localparam int QUOT_W       = RECIP_PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 26'd34359739;

    // Register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_SPEED  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW = 2'd3;

    // Register reset values
    localparam logic [SPEED_W-1:0] SPEED_RST  = 9'd343;
    localparam logic [DIST_W-1:0]  MIN_RST    = 14'd20;
    localparam logic [DIST_W-1:0]  MAX_RST    = 14'd4000;
    localparam logic [WSIZE_W-1:0] WINDOW_RST = 4'd3;

    // Input word: one ping
    typedef struct packed {
        logic               echo_seen;
        logic [WIDTH_W-1:0] pulse_width_us;
    } ping_t;

    // Output word: one range report
    typedef struct packed {
        logic [DIST_W-1:0] distance_mm;
        logic              distance_valid;
        logic              from_median;
    } range_t;

    // Configuration registers
    typedef struct packed {
        logic [SPEED_W-1:0] sound_speed_mps;
        logic [DIST_W-1:0]  min_range_mm;
        logic [DIST_W-1:0]  max_range_mm;
        logic [WSIZE_W-1:0] window_size;
    } cfg_t;

    // Converted distance on its way to the window stage
    typedef struct packed {
        logic              vld;
        logic              echo;
        logic [QUOT_W-1:0] dist_mm;
    } dist_stage_t;

    // Reading after the window stage
    typedef struct packed {
        logic              vld;
        logic [DIST_W-1:0] value;
        logic              valid;
        logic              med;
    } mid_stage_t;

    // Ring of stored distances
    typedef logic [MAX_WINDOW-1:0][DIST_W-1:0] ring_t;

    // Effective window: zero acts as one, even raised by one, capped at depth
    function automatic logic [WIN_W-1:0] eff_window(input logic [WSIZE_W-1:0] ws);
        logic [WSIZE_W:0] w;
        w = {1'b0, ws};
        if (w == '0)
        begin
            w = (WSIZE_W+1)'(1);
        end
        if (!w[0])
        begin
            w = w + (WSIZE_W+1)'(1);
        end
        if (w > (WSIZE_W+1)'(MAX_WINDOW))
        begin
            w = (WSIZE_W+1)'(MAX_WINDOW);
        end
        return w[WIN_W-1:0];
    endfunction

endpackage

// ===== rtl/urm_dist.sv =====
// ----------------------------------------------------------------------------
// urm_dist
// Input register and distance conversion: pulse width times sound speed,
// then an exact divide by 2000 through a reciprocal multiply.
// ----------------------------------------------------------------------------
module urm_dist (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  ping_valid,
    output logic                  ping_stall,
    input  urm_pkg::ping_t        ping,
    input  logic [urm_pkg::SPEED_W-1:0] sound_speed_mps,
    input  logic                  take_dist,
    output urm_pkg::dist_stage_t  dist_stage
);
    import urm_pkg::*;

    logic               in_vld_reg;
    ping_t              in_reg;
    logic               prod_vld_reg;
    logic               prod_echo_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic               dist_vld_reg;
    logic               dist_echo_reg;
    logic [QUOT_W-1:0]  dist_reg;
    logic [RECIP_PROD_W-1:0] recip_prod;
    logic               en_in;
    logic               en_prod;
    logic               en_dist;

    // Each stage loads when empty or when the next one takes its word
    assign en_dist    = !dist_vld_reg || take_dist;
    assign en_prod    = !prod_vld_reg || en_dist;
    assign en_in      = !in_vld_reg || en_prod;
    assign ping_stall = !en_in;

    // Multiply width by sound speed
    assign prod_next = PROD_W'(in_reg.pulse_width_us) * PROD_W'(sound_speed_mps);

    // Divide by 2000 through the reciprocal
    assign recip_prod = RECIP_PROD_W'(prod_reg) * RECIP_PROD_W'(RECIP_MULT);

    // Stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            dist_vld_reg <= 1'b0;
        end
        else
        begin
            if (en_in)
            begin
                in_vld_reg <= ping_valid;
            end
            if (en_prod)
            begin
                prod_vld_reg <= in_vld_reg;
            end
            if (en_dist)
            begin
                dist_vld_reg <= prod_vld_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en_in && ping_valid)
        begin
            in_reg <= ping;
        end
        if (en_prod && in_vld_reg)
        begin
            prod_reg      <= prod_next;
            prod_echo_reg <= in_reg.echo_seen;
        end
        if (en_dist && prod_vld_reg)
        begin
            dist_reg      <= recip_prod[RECIP_SHIFT +: QUOT_W];
            dist_echo_reg <= prod_echo_reg;
        end
    end

    assign dist_stage.vld     = dist_vld_reg;
    assign dist_stage.echo    = dist_echo_reg;
    assign dist_stage.dist_mm = dist_reg;

endmodule

// ===== rtl/urm_window.sv =====
// ----------------------------------------------------------------------------
// urm_window
// Range check and ring update: valid distances enter a ring of the last W
// values; flags whether the word leaves as the window median.
// ----------------------------------------------------------------------------
module urm_window (
    input  logic                  clk,
    input  logic                  rst_n,
    input  urm_pkg::cfg_t         cfg,
    input  logic                  win_clear,
    input  urm_pkg::dist_stage_t  dist_stage,
    output logic                  take_dist,
    input  logic                  take_mid,
    output urm_pkg::mid_stage_t   mid_stage,
    output urm_pkg::ring_t        ring,
    output logic [urm_pkg::WIN_W-1:0] win_len
);
    import urm_pkg::*;

    ring_t              store_reg;
    logic [WIN_W-1:0]   fill_reg;
    logic [WIN_W-1:0]   fill_next;
    logic [SLOT_W-1:0]  oldest_reg;
    logic [SLOT_W-1:0]  oldest_next;
    logic               mid_vld_reg;
    logic [DIST_W-1:0]  mid_value_reg;
    logic               mid_valid_reg;
    logic               mid_med_reg;
    logic               en_mid;
    logic               move;
    logic               in_range;
    logic               filter_on;
    logic               wr_en;
    logic [WIN_W:0]     wrap_sum;
    logic [SLOT_W-1:0]  wr_slot;
    logic [SLOT_W-1:0]  oldest_wrap;
    logic [WIN_W:0]     oldest_inc;

    assign win_len   = eff_window(cfg.window_size);
    assign filter_on = win_len > WIN_W'(1);

    // Advance when empty or when the output side takes the word
    assign en_mid    = !mid_vld_reg || take_mid;
    assign take_dist = en_mid;
    assign move      = en_mid && dist_stage.vld;

    // Range check
    assign in_range = dist_stage.echo
                   && (dist_stage.dist_mm >= QUOT_W'(cfg.min_range_mm))
                   && (dist_stage.dist_mm <= QUOT_W'(cfg.max_range_mm));

    assign wr_en = move && filter_on && in_range;

    // Pick the slot: append while filling, else overwrite the oldest
    always_comb
    begin
        wrap_sum    = (WIN_W+1)'(oldest_reg) + (WIN_W+1)'(fill_reg);
        oldest_wrap = oldest_reg;
        oldest_next = oldest_reg;
        fill_next   = fill_reg;
        if ((WIN_W+1)'(oldest_reg) >= (WIN_W+1)'(win_len))
        begin
            oldest_wrap = SLOT_W'((WIN_W+1)'(oldest_reg) - (WIN_W+1)'(win_len));
        end
        oldest_inc = (WIN_W+1)'(oldest_wrap) + (WIN_W+1)'(1);
        if (fill_reg < win_len)
        begin
            if (wrap_sum >= (WIN_W+1)'(win_len))
            begin
                wrap_sum = wrap_sum - (WIN_W+1)'(win_len);
            end
            wr_slot = SLOT_W'(wrap_sum);
            if (wr_en)
            begin
                fill_next = fill_reg + WIN_W'(1);
            end
        end
        else
        begin
            wr_slot = oldest_wrap;
            if (wr_en)
            begin
                if (oldest_inc == (WIN_W+1)'(win_len))
                begin
                    oldest_next = '0;
                end
                else
                begin
                    oldest_next = SLOT_W'(oldest_inc);
                end
            end
        end
    end

    // Ring bookkeeping and stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            oldest_reg  <= '0;
            mid_vld_reg <= 1'b0;
        end
        else
        begin
            if (win_clear)
            begin
                fill_reg   <= '0;
                oldest_reg <= '0;
            end
            else
            begin
                fill_reg   <= fill_next;
                oldest_reg <= oldest_next;
            end
            if (en_mid)
            begin
                mid_vld_reg <= dist_stage.vld;
            end
        end
    end

    // Ring storage and stage payload
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_slot] <= dist_stage.dist_mm[DIST_W-1:0];
        end
        if (move)
        begin
            mid_value_reg <= in_range ? dist_stage.dist_mm[DIST_W-1:0] : '0;
            mid_valid_reg <= in_range;
            mid_med_reg   <= filter_on && (fill_next == win_len);
        end
    end

    assign ring            = store_reg;
    assign mid_stage.vld   = mid_vld_reg;
    assign mid_stage.value = mid_value_reg;
    assign mid_stage.valid = mid_valid_reg;
    assign mid_stage.med   = mid_med_reg;

    // Fill never passes the window
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= win_len)
        else $error("window fill above window length");

    // Oldest slot stays inside the window
    a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (oldest_reg == '0) || ((WIN_W+1)'(oldest_reg) < (WIN_W+1)'(win_len)))
        else $error("oldest slot outside window");

    // Ring only changes when a word moves forward
    a_write_on_move: assert property (@(posedge clk) disable iff (!rst_n)
        !move |=> $stable(fill_reg) || $past(win_clear))
        else $error("ring fill changed without a word");

endmodule

// ===== rtl/urm_median.sv =====
// ----------------------------------------------------------------------------
// urm_median
// Median select by rank counting over the ring, and the output register.
// ----------------------------------------------------------------------------
module urm_median (
    input  logic                  clk,
    input  logic                  rst_n,
    input  urm_pkg::mid_stage_t   mid_stage,
    input  urm_pkg::ring_t        ring,
    input  logic [urm_pkg::WIN_W-1:0] win_len,
    output logic                  take_mid,
    output logic                  range_valid,
    input  logic                  range_stall,
    output urm_pkg::range_t       range
);
    import urm_pkg::*;

    logic                   out_vld_reg;
    range_t                 out_reg;
    range_t                 out_next;
    logic [WIN_W-1:0]       mid_rank;
    logic [MAX_WINDOW-1:0]  hit;
    logic [DIST_W-1:0]      med_value;
    logic                   en_out;

    assign en_out   = !out_vld_reg || !range_stall;
    assign take_mid = en_out;

    // Rank each live slot (ties broken by slot order), pick rank W/2
    always_comb
    begin
        logic [WIN_W-1:0] rank;
        mid_rank  = win_len >> 1;
        hit       = '0;
        med_value = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            rank = '0;
            for (int j = 0; j < MAX_WINDOW; j++)
            begin
                if ((WIN_W'(j) < win_len)
                    && ((ring[j] < ring[i]) || ((ring[j] == ring[i]) && (j < i))))
                begin
                    rank = rank + WIN_W'(1);
                end
            end
            hit[i] = (WIN_W'(i) < win_len) && (rank == mid_rank);
            if (hit[i])
            begin
                med_value = med_value | ring[i];
            end
        end
    end

    // Replace the reading by the median once the ring is full
    always_comb
    begin
        out_next.distance_mm    = mid_stage.med ? med_value : mid_stage.value;
        out_next.distance_valid = mid_stage.med || mid_stage.valid;
        out_next.from_median    = mid_stage.med;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_vld_reg <= mid_stage.vld;
        end
    end

    // Hold the word while stalled
    always_ff @(posedge clk)
    begin
        if (en_out && mid_stage.vld)
        begin
            out_reg <= out_next;
        end
    end

    assign range_valid = out_vld_reg;
    assign range       = out_reg;

    // A full ring has exactly one slot at the median rank
    a_one_median: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_stage.vld && mid_stage.med) |-> $onehot(hit))
        else $error("median select not unique");

    // A median word is always a valid distance
    a_median_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (range_valid && range.from_median) |-> range.distance_valid)
        else $error("median word flagged invalid");

endmodule

// ===== rtl/ultrasonic_range_median_top.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_range_median_top
// Ultrasonic ping to distance converter with a sliding median filter.
//
// Input channel (ping_valid / ping_stall / ping): one word per echo result,
// echo flag and pulse width in microseconds. Output channel (range_valid /
// range_stall / range): one word per ping, distance in mm, valid flag and a
// flag telling whether the value is the window median.
// A word is taken at an edge with valid high and stall low.
// Throughput: one word per cycle while range_stall is low; five register
// stages (input, product, reciprocal divide, window, output) each hold one word.
// When the receiver stalls, the output word holds and the upstream stages
// keep filling their empty slots; ping_stall rises once all are occupied.
// Reset empties the pipeline and the ring and loads the register defaults
// (343 m/s, 20 mm, 4000 mm, window 3). Writing the window register empties
// the ring. Registers sit on an APB-style port at byte addresses 0, 4, 8, 12;
// the user must write them only while no ping is in flight; it is not enforced.
// ----------------------------------------------------------------------------
module ultrasonic_range_median_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  ping_valid,
    output logic                  ping_stall,
    input  urm_pkg::ping_t        ping,
    output logic                  range_valid,
    input  logic                  range_stall,
    output urm_pkg::range_t       range,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [urm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [urm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [urm_pkg::APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    import urm_pkg::*;

    cfg_t                cfg_reg;
    logic                cfg_wr;
    logic                win_clear;
    logic [REG_IDX_W-1:0] reg_idx;
    dist_stage_t         dist_stage;
    mid_stage_t          mid_stage;
    ring_t               ring;
    logic [WIN_W-1:0]    win_len;
    logic                take_dist;
    logic                take_mid;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1 -: REG_IDX_W];
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign win_clear = cfg_wr && (reg_idx == REG_WINDOW);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sound_speed_mps <= SPEED_RST;
            cfg_reg.min_range_mm    <= MIN_RST;
            cfg_reg.max_range_mm    <= MAX_RST;
            cfg_reg.window_size     <= WINDOW_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_SPEED:  cfg_reg.sound_speed_mps <= pwdata[SPEED_W-1:0];
                REG_MIN:    cfg_reg.min_range_mm    <= pwdata[DIST_W-1:0];
                REG_MAX:    cfg_reg.max_range_mm    <= pwdata[DIST_W-1:0];
                REG_WINDOW: cfg_reg.window_size     <= pwdata[WSIZE_W-1:0];
                default:    cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_idx)
            REG_SPEED:  prdata = APB_DATA_W'(cfg_reg.sound_speed_mps);
            REG_MIN:    prdata = APB_DATA_W'(cfg_reg.min_range_mm);
            REG_MAX:    prdata = APB_DATA_W'(cfg_reg.max_range_mm);
            REG_WINDOW: prdata = APB_DATA_W'(cfg_reg.window_size);
            default:    prdata = '0;
        endcase
    end

    urm_dist u_dist (
        .clk             (clk),
        .rst_n           (rst_n),
        .ping_valid      (ping_valid),
        .ping_stall      (ping_stall),
        .ping            (ping),
        .sound_speed_mps (cfg_reg.sound_speed_mps),
        .take_dist       (take_dist),
        .dist_stage      (dist_stage)
    );

    urm_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .win_clear  (win_clear),
        .dist_stage (dist_stage),
        .take_dist  (take_dist),
        .take_mid   (take_mid),
        .mid_stage  (mid_stage),
        .ring       (ring),
        .win_len    (win_len)
    );

    urm_median u_median (
        .clk         (clk),
        .rst_n       (rst_n),
        .mid_stage   (mid_stage),
        .ring        (ring),
        .win_len     (win_len),
        .take_mid    (take_mid),
        .range_valid (range_valid),
        .range_stall (range_stall),
        .range       (range)
    );

endmodule
